@@ rtl/olv_pkg.sv @@
package olv_pkg;

  // List geometry
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned POS_W    = $clog2(CAPACITY);
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned VAL_W    = 32;

  // Request codes
  typedef enum logic [2:0] {
    REQ_INS_HEAD  = 3'd0,
    REQ_INS_TAIL  = 3'd1,
    REQ_RM_HEAD   = 3'd2,
    REQ_RM_VALUE  = 3'd3,
    REQ_CONTAINS  = 3'd4,
    REQ_READ_IDX  = 3'd5,
    REQ_READ_HEAD = 3'd6,
    REQ_NOP       = 3'd7
  } olv_req_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_RANGE    = 3'd5
  } olv_status_e;

  // Sequencer states
  typedef enum logic {
    OLV_IDLE,
    OLV_EXEC
  } olv_state_e;

  // Commands broadcast to every cell of the chain
  typedef struct packed {
    logic capture;    // register the compare of each entry against the new key
    logic push_head;  // shift every entry one place toward the tail
    logic push_tail;  // load the key into the first free cell
    logic remove;     // shift entries at and after the removed place toward the head
  } olv_cell_ctl_t;

endpackage

@@ rtl/olv_cell.sv @@
module olv_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  olv_pkg::olv_cell_ctl_t              ctl_i,
  input  logic [olv_pkg::VAL_W-1:0]           cmp_key_i,
  input  logic [olv_pkg::VAL_W-1:0]           load_key_i,
  input  logic                                valid_i,
  input  logic                                tail_i,
  input  logic [olv_pkg::VAL_W-1:0]           prev_val_i,
  input  logic [olv_pkg::VAL_W-1:0]           next_val_i,
  input  logic                                seen_i,
  output logic [olv_pkg::VAL_W-1:0]           val_o,
  output logic                                match_o,
  output logic                                seen_o
);
  import olv_pkg::*;

  logic [VAL_W-1:0] value_q, value_d;
  logic             match_q, match_d;

  // Select the entry's next value from the neighbors or the key
  always_comb begin
    value_d = value_q;
    if (ctl_i.push_head) begin
      value_d = prev_val_i;
    end else if (ctl_i.push_tail && tail_i) begin
      value_d = load_key_i;
    end else if (ctl_i.remove && (seen_i || match_q)) begin
      value_d = next_val_i;
    end
  end

  // Compare the held entry with the incoming key
  assign match_d = ctl_i.capture ? (valid_i && (value_q == cmp_key_i)) : match_q;

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  // Pass the removal mark down the chain
  assign seen_o  = seen_i || match_q;
  assign val_o   = value_q;
  assign match_o = match_q;

endmodule

@@ rtl/ordered_unique_value_list_top.sv @@
// Ordered list of up to 16 distinct signed 32-bit values, head at position 0.
// Input channel: in_valid_i / in_stall_o with req_type_i, value_i, index_i.
// Output channel: out_valid_o / out_stall_i with data_o, found_o, status_o,
// count_o. Each request gives exactly one result transaction.
// The list lives in a chain of cells. In the accept cycle every cell compares
// its entry with value_i and registers the match; in the next cycle the
// sequencer decides the request, and once the output register is free all
// cells shift or load at once and the result is loaded into that register.
// A new request is not accepted until the previous one has finished its
// update cycle of the chain, which follows its compare cycle.
// The output register holds a finished result while the receiver stalls; the
// next request may be accepted meanwhile, but its update cycle waits until
// the output register is free, and in_stall_o stays high until then.
// Reset empties the list (count zero) and drops any pending result. Entries
// themselves are not cleared; only positions below the count are ever read.
module ordered_unique_value_list_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         req_type_i,
  input  logic signed [olv_pkg::VAL_W-1:0]   value_i,
  input  logic [olv_pkg::IDX_W-1:0]          index_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [olv_pkg::VAL_W-1:0]   data_o,
  output logic                               found_o,
  output logic [2:0]                         status_o,
  output logic [olv_pkg::COUNT_W-1:0]        count_o
);
  import olv_pkg::*;

  olv_state_e state_q, state_d;

  logic [2:0]         req_q;
  logic [VAL_W-1:0]   key_q;
  logic [IDX_W-1:0]   index_q;
  logic [COUNT_W-1:0] count_q, count_d;

  logic               out_valid_q;
  logic [VAL_W-1:0]   data_q;
  logic               found_q;
  logic [2:0]         status_q;

  logic capture, exec_fire;

  logic [CAPACITY-1:0][VAL_W-1:0] cell_val;
  logic [CAPACITY-1:0]            cell_match;
  logic [CAPACITY:0]              seen_chain;
  olv_cell_ctl_t                  ctl;

  logic               hit, empty, full;
  logic [VAL_W-1:0]   res_data;
  logic               res_found;
  olv_status_e        res_status;
  logic               op_push_head, op_push_tail, op_remove, op_rm_head;
  logic [POS_W-1:0]   rd_pos;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      OLV_IDLE: if (in_valid_i) state_d = OLV_EXEC;
      OLV_EXEC: if (exec_fire)  state_d = OLV_IDLE;
      default:  state_d = OLV_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    capture    = 1'b0;
    exec_fire  = 1'b0;
    unique case (state_q)
      OLV_IDLE: begin
        in_stall_o = 1'b0;
        capture    = in_valid_i;
      end
      OLV_EXEC: begin
        exec_fire = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OLV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk_i) begin
    if (capture) begin
      req_q   <= req_type_i;
      key_q   <= $unsigned(value_i);
      index_q <= index_i;
    end
  end

  // Decide the request from the registered matches
  assign hit    = |cell_match;
  assign empty  = (count_q == '0);
  assign full   = (count_q == COUNT_W'(CAPACITY));
  assign rd_pos = POS_W'(index_q);

  always_comb begin
    res_data     = '0;
    res_found    = 1'b0;
    res_status   = ST_OK;
    op_push_head = 1'b0;
    op_push_tail = 1'b0;
    op_remove    = 1'b0;
    op_rm_head   = 1'b0;
    count_d      = count_q;
    unique case (olv_req_e'(req_q))
      REQ_INS_HEAD, REQ_INS_TAIL: begin
        if (hit) begin
          res_status = ST_DUP;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          op_push_head = (olv_req_e'(req_q) == REQ_INS_HEAD);
          op_push_tail = (olv_req_e'(req_q) == REQ_INS_TAIL);
          count_d      = count_q + COUNT_W'(1);
        end
      end
      REQ_RM_HEAD: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_data   = cell_val[0];
          op_remove  = 1'b1;
          op_rm_head = 1'b1;
          count_d    = count_q - COUNT_W'(1);
        end
      end
      REQ_RM_VALUE: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else if (hit) begin
          // the removed entry equals the key
          res_data  = key_q;
          op_remove = 1'b1;
          count_d   = count_q - COUNT_W'(1);
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      REQ_CONTAINS: begin
        res_found = hit;
      end
      REQ_READ_IDX: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else if (COUNT_W'(index_q) >= count_q) begin
          res_status = ST_RANGE;
        end else begin
          res_data = cell_val[rd_pos];
        end
      end
      REQ_READ_HEAD: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_data = cell_val[0];
        end
      end
      REQ_NOP: ;
      default: ;
    endcase
  end

  // Drive the cell commands
  assign ctl.capture   = capture;
  assign ctl.push_head = exec_fire && op_push_head;
  assign ctl.push_tail = exec_fire && op_push_tail;
  assign ctl.remove    = exec_fire && op_remove;
  assign seen_chain[0] = op_rm_head;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] prev_val, next_val;
    logic             cell_valid, cell_tail;

    assign prev_val   = (i == 0) ? key_q : cell_val[(i == 0) ? 0 : i - 1];
    assign next_val   = (i == CAPACITY - 1) ? cell_val[i]
                                            : cell_val[(i == CAPACITY - 1) ? i : i + 1];
    assign cell_valid = (COUNT_W'(i) < count_q);
    assign cell_tail  = (COUNT_W'(i) == count_q);

    olv_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .cmp_key_i  ($unsigned(value_i)),
      .load_key_i (key_q),
      .valid_i    (cell_valid),
      .tail_i     (cell_tail),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .seen_i     (seen_chain[i]),
      .val_o      (cell_val[i]),
      .match_o    (cell_match[i]),
      .seen_o     (seen_chain[i+1])
    );
  end

  // Advance the count and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      data_q   <= res_data;
      found_q  <= res_found;
      status_q <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = $signed(data_q);
  assign found_o     = found_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(CAPACITY))
    else $error("count exceeds capacity");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && state_q == OLV_EXEC))
    else $error("accepted transaction did not start the update cycle");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == OLV_EXEC) |-> $onehot0(cell_match))
    else $error("list holds a value twice");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec_fire |=> $stable(count_q))
    else $error("count changed outside an update cycle");
`endif

endmodule

@@ tb/ordered_unique_value_list_top_test.sv @@
module ordered_unique_value_list_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import olv_pkg::*;

  // One result transaction as it leaves the block
  typedef struct packed {
    logic signed [VAL_W-1:0] data;
    logic                    found;
    olv_status_e             status;
    logic [COUNT_W-1:0]      count;
  } list_result_t;

  // One row of the directed table; reps > 1 sends consecutive values
  typedef struct {
    olv_req_e         rq;
    logic [VAL_W-1:0] v;
    logic [IDX_W-1:0] ix;
    int               reps;
    bit               typed;
    list_result_t     want;
  } directed_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [2:0]                req_type_i;
  logic signed [VAL_W-1:0]   value_i;
  logic [IDX_W-1:0]          index_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [VAL_W-1:0]   data_o;
  logic                      found_o;
  logic [2:0]                status_o;
  logic [COUNT_W-1:0]        count_o;

  logic signed [VAL_W-1:0] model_list[$];
  list_result_t            awaited_results[$];
  directed_row_t           directed_rows[$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int requests_sent  = 0;
  int full_hits      = 0;
  int empty_hits     = 0;
  int dup_hits       = 0;
  int stall_left     = 0;
  bit quiet_phase    = 1'b0;

  ordered_unique_value_list_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .index_i     (index_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (data_o),
    .found_o     (found_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  // Generate the 20 ns clock
  always begin
    clk_i = 1'b0;
    #10ns;
    clk_i = 1'b1;
    #10ns;
  end

  // Gap length: half the time none, else mostly short, a few long; none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(12, 30);
  endfunction

  // Apply one request to the list copy and return the result it gives
  function automatic list_result_t apply_list_request(olv_req_e rq, logic [VAL_W-1:0] v,
                                                       logic [IDX_W-1:0] ix);
    list_result_t r;
    int pos;
    r.data   = '0;
    r.found  = 1'b0;
    r.status = ST_OK;
    pos = -1;
    for (int i = 0; i < model_list.size(); i++) begin
      if (pos < 0 && model_list[i] == v) pos = i;
    end
    case (rq)
      REQ_INS_HEAD, REQ_INS_TAIL: begin
        // duplicate check wins over the full check
        if (pos >= 0) r.status = ST_DUP;
        else if (model_list.size() >= CAPACITY) r.status = ST_FULL;
        else if (rq == REQ_INS_HEAD) model_list.push_front(v);
        else model_list.push_back(v);
      end
      REQ_RM_HEAD: begin
        if (model_list.size() == 0) r.status = ST_EMPTY;
        else r.data = model_list.pop_front();
      end
      REQ_RM_VALUE: begin
        if (model_list.size() == 0) r.status = ST_EMPTY;
        else if (pos < 0) r.status = ST_NOTFOUND;
        else begin
          r.data = model_list[pos];
          model_list.delete(pos);
        end
      end
      REQ_CONTAINS: r.found = (pos >= 0);
      REQ_READ_IDX: begin
        if (model_list.size() == 0) r.status = ST_EMPTY;
        else if (ix >= model_list.size()) r.status = ST_RANGE;
        else r.data = model_list[ix];
      end
      REQ_READ_HEAD: begin
        if (model_list.size() == 0) r.status = ST_EMPTY;
        else r.data = model_list[0];
      end
      default: ;
    endcase
    r.count = COUNT_W'(model_list.size());
    return r;
  endfunction

  function automatic void add_row(olv_req_e rq, logic [VAL_W-1:0] v, logic [IDX_W-1:0] ix,
                                  int reps, bit typed, logic [VAL_W-1:0] d, logic f,
                                  olv_status_e st, logic [COUNT_W-1:0] c);
    directed_row_t row;
    row.rq          = rq;
    row.v           = v;
    row.ix          = ix;
    row.reps        = reps;
    row.typed       = typed;
    row.want.data   = d;
    row.want.found  = f;
    row.want.status = st;
    row.want.count  = c;
    directed_rows.push_back(row);
  endfunction

  // Drive one request transaction, hold it until taken, then record its result
  task automatic send_request(input olv_req_e rq, input logic [VAL_W-1:0] v,
                              input logic [IDX_W-1:0] ix, input bit typed,
                              input list_result_t typed_res);
    int gap;
    list_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rq;
    value_i    <= v;
    index_i    <= ix;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
    predicted = apply_list_request(rq, v, ix);
    if (predicted.status == ST_FULL) full_hits++;
    if (predicted.status == ST_EMPTY) empty_hits++;
    if (predicted.status == ST_DUP) dup_hits++;
    awaited_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
  endtask

  // Stall the result side in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet_phase && $urandom_range(0, 99) < 30) begin
      stall_left = pick_gap();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted result transaction with the oldest expectation
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: data %0d found %0b status %0d count %0d",
                   data_o, found_o, status_o, count_o);
      end else begin
        want = awaited_results.pop_front();
        if (data_o !== want.data || found_o !== want.found ||
            status_o !== want.status || count_o !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: data %0d/%0d found %0b/%0b status %0d/%0d count %0d/%0d",
                     data_o, want.data, found_o, want.found, status_o, want.status,
                     count_o, want.count);
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #4ms;
    $display("ordered_unique_value_list_top verification failed");
    $finish;
  end

  initial begin
    olv_req_e         rq;
    logic [VAL_W-1:0] v;
    logic [IDX_W-1:0] ix;
    int               mode;
    int               r;
    int               drain_wait;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_NOP;
    value_i     = '0;
    index_i     = '0;

    // Empty list corners, extremes, duplicates, range, then fill past capacity
    add_row(REQ_READ_HEAD, 32'd5, 4'd0, 1, 1, 32'd0, 1'b0, ST_EMPTY, 5'd0);
    add_row(REQ_RM_HEAD, 32'd5, 4'd0, 1, 1, 32'd0, 1'b0, ST_EMPTY, 5'd0);
    add_row(REQ_RM_VALUE, 32'd5, 4'd0, 1, 1, 32'd0, 1'b0, ST_EMPTY, 5'd0);
    add_row(REQ_CONTAINS, 32'd5, 4'd0, 1, 1, 32'd0, 1'b0, ST_OK, 5'd0);
    add_row(REQ_READ_IDX, 32'd0, 4'd0, 1, 1, 32'd0, 1'b0, ST_EMPTY, 5'd0);
    add_row(REQ_NOP, 32'hFFFF_FFFF, 4'hF, 1, 1, 32'd0, 1'b0, ST_OK, 5'd0);
    add_row(REQ_INS_HEAD, 32'h7FFF_FFFF, 4'd0, 1, 1, 32'd0, 1'b0, ST_OK, 5'd1);
    add_row(REQ_INS_TAIL, 32'h8000_0000, 4'd0, 1, 1, 32'd0, 1'b0, ST_OK, 5'd2);
    add_row(REQ_INS_HEAD, 32'h7FFF_FFFF, 4'd0, 1, 1, 32'd0, 1'b0, ST_DUP, 5'd2);
    add_row(REQ_CONTAINS, 32'h8000_0000, 4'd0, 1, 1, 32'd0, 1'b1, ST_OK, 5'd2);
    add_row(REQ_READ_IDX, 32'd0, 4'd2, 1, 1, 32'd0, 1'b0, ST_RANGE, 5'd2);
    add_row(REQ_READ_IDX, 32'd0, 4'd1, 1, 1, 32'h8000_0000, 1'b0, ST_OK, 5'd2);
    add_row(REQ_INS_TAIL, 32'hFFFF_FFF9, 4'd0, 13, 0, 32'd0, 1'b0, ST_OK, 5'd0);
    add_row(REQ_INS_HEAD, 32'h1234_5678, 4'd0, 1, 1, 32'd0, 1'b0, ST_OK, 5'd16);
    add_row(REQ_INS_TAIL, 32'd100, 4'd0, 1, 1, 32'd0, 1'b0, ST_FULL, 5'd16);
    add_row(REQ_INS_TAIL, 32'hFFFF_FFF9, 4'd0, 1, 1, 32'd0, 1'b0, ST_DUP, 5'd16);
    add_row(REQ_READ_IDX, 32'd0, 4'd15, 1, 0, 32'd0, 1'b0, ST_OK, 5'd0);
    add_row(REQ_READ_HEAD, 32'd0, 4'd0, 1, 0, 32'd0, 1'b0, ST_OK, 5'd0);
    add_row(REQ_CONTAINS, 32'd999, 4'd0, 1, 0, 32'd0, 1'b0, ST_OK, 5'd0);
    add_row(REQ_RM_VALUE, 32'd999, 4'd0, 1, 1, 32'd0, 1'b0, ST_NOTFOUND, 5'd16);
    add_row(REQ_RM_VALUE, 32'd0, 4'd0, 1, 0, 32'd0, 1'b0, ST_OK, 5'd0);
    add_row(REQ_RM_VALUE, 32'd5, 4'd0, 1, 0, 32'd0, 1'b0, ST_OK, 5'd0);
    add_row(REQ_RM_HEAD, 32'd0, 4'd0, 1, 0, 32'd0, 1'b0, ST_OK, 5'd0);
    add_row(REQ_READ_IDX, 32'd0, 4'd15, 1, 0, 32'd0, 1'b0, ST_OK, 5'd0);

    // Hold reset, then release it on a falling edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    foreach (directed_rows[k]) begin
      for (int j = 0; j < directed_rows[k].reps; j++)
        send_request(directed_rows[k].rq, directed_rows[k].v + j, directed_rows[k].ix,
                     directed_rows[k].typed, directed_rows[k].want);
    end

    // Random part: alternate fill-heavy, drain-heavy and mixed stretches
    for (int n = 0; n < 400; n++) begin
      quiet_phase = ((n / 40) % 4) == 3;
      mode = (n / 60) % 3;
      r = $urandom_range(0, 99);
      if (r < 2) rq = REQ_NOP;
      else if (r < 55 && mode == 0) rq = $urandom_range(0, 1) ? REQ_INS_TAIL : REQ_INS_HEAD;
      else if (r < 55 && mode == 1) rq = $urandom_range(0, 1) ? REQ_RM_VALUE : REQ_RM_HEAD;
      else rq = olv_req_e'($urandom_range(0, 6));

      // favor held values and a small pool so hits and duplicates are common
      r = $urandom_range(0, 99);
      if (r < 45 && model_list.size() > 0)
        v = model_list[$urandom_range(0, model_list.size() - 1)];
      else if (r < 75) v = 32'($urandom_range(0, 15)) - 32'd8;
      else if (r < 82) v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      else v = $urandom;

      if (model_list.size() > 0 && $urandom_range(0, 1))
        ix = IDX_W'($urandom_range(0, model_list.size() - 1));
      else ix = IDX_W'($urandom_range(0, 15));

      send_request(rq, v, ix, 1'b0, '0);
    end
    quiet_phase = 1'b0;
    in_valid_i <= 1'b0;

    // Drain outstanding results, then allow for the pipeline latency
    drain_wait = 0;
    while (awaited_results.size() > 0 && drain_wait < 5000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (8) @(posedge clk_i);
    if (awaited_results.size() > 0) begin
      mismatch_count += awaited_results.size();
      $display("%0d expected results never arrived", awaited_results.size());
    end

    $display("sent %0d requests and checked %0d results, %0d mismatches",
             requests_sent, results_seen, mismatch_count);
    $display("list full on %0d inserts, empty on %0d requests, %0d duplicates rejected",
             full_hits, empty_hits, dup_hits);
    if (mismatch_count == 0) begin
      $display("ordered_unique_value_list_top verification clean");
    end else begin
      $display("ordered_unique_value_list_top verification failed");
    end
    $finish;
  end

endmodule

@@ ordered_unique_value_list_top.f @@
rtl/olv_pkg.sv
rtl/olv_cell.sv
rtl/ordered_unique_value_list_top.sv
tb/ordered_unique_value_list_top_test.sv
